// ===== src/fkhc_pkg.sv =====
// ----------------------------------------------------------------------------
// fkhc_pkg
// Shared types and constants of the keyed handle cache.
// ----------------------------------------------------------------------------
package fkhc_pkg;

  localparam int CACHE_ENTRIES = 16;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 24;
  localparam int COUNT_W  = 5;
  localparam int STORED_W = 28;

  // Fill counter must hold CACHE_ENTRIES itself.
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  // Running size sum, at least one bit wider than the reported field.
  localparam int SUM_W = (SIZE_W + CNT_W > STORED_W) ? SIZE_W + CNT_W : STORED_W + 1;
  localparam logic [STORED_W-1:0] STORED_MAX = {STORED_W{1'b1}};

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic             add;     // committed add of a new entry
    logic             shift;   // add into a full table: every cell takes its upper neighbor
    logic             flush;   // committed flush
    logic             lookup;  // find with a nonzero key (combinational compare)
    logic             commit;  // transaction accepted this cycle
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  // Match chain passed from newer cells to older ones.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
  } match_t;

endpackage

// ===== src/fifo_keyed_handle_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_keyed_handle_cache
// FIFO-replacement cache of keyed object handles built as a row of entry
// cells with per-cell key compare and a newest-first match chain.
// ----------------------------------------------------------------------------
// A result is in the output register in the cycle after its transaction is
// accepted. Throughput: one transaction per cycle; the input is ready
// whenever the output register is empty or is being taken, and all cells
// update in the same cycle as the lookup. Reset (synchronous, rst_n low)
// empties the table, clears the running size and the output valid flag.
module fifo_keyed_handle_cache import fkhc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key[31:0], handle[63:32], frame_size[87:64]
  input  logic [1:0]             in_tuser,   // cmd[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found_handle[31:0], evicted_handle[63:32],
                                             // entry_count[68:64], stored_size[96:69]
  output logic [1:0]             out_tuser   // status[1:0]
);

  cmd_t      cmd;
  entry_t    new_ent;
  cell_ctl_t ctl;
  logic      commit, full, cell0_counted;

  entry_t ent      [CACHE_ENTRIES];
  logic   valid    [CACHE_ENTRIES];
  entry_t up_ent   [CACHE_ENTRIES];
  logic   up_valid [CACHE_ENTRIES];
  logic   low_valid[CACHE_ENTRIES];
  match_t chain    [CACHE_ENTRIES+1];

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t                status_r, status_nxt;

  logic [HANDLE_W-1:0] found, evicted;
  logic [STORED_W-1:0] stored;
  logic                add_ok;

  assign cmd            = cmd_t'(in_tuser);
  assign new_ent.key    = in_tdata[31:0];
  assign new_ent.handle = in_tdata[63:32];
  assign new_ent.size   = in_tdata[87:64];

  assign in_tready = !out_valid_r || out_tready;
  assign commit    = in_tvalid && in_tready;
  assign full      = (fill_r == CNT_W'(CACHE_ENTRIES));
  assign add_ok    = (cmd == CMD_ADD) && new_ent.key != '0 && new_ent.handle != '0;

  always_comb begin
    ctl.add    = commit && add_ok;
    ctl.shift  = commit && add_ok && full;
    ctl.flush  = commit && (cmd == CMD_FLUSH);
    ctl.lookup = (cmd == CMD_FIND) && new_ent.key != '0;
    ctl.commit = commit;
    ctl.key    = new_ent.key;
  end

  // Neighbor wiring: the newest cell shifts in the new entry.
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (i == CACHE_ENTRIES - 1) begin
        up_ent[i]   = new_ent;
        up_valid[i] = 1'b1;
      end else begin
        up_ent[i]   = ent[i+1];
        up_valid[i] = valid[i+1];
      end
      low_valid[i] = (i == 0) ? 1'b1 : valid[(i == 0) ? 0 : i-1];
    end
  end

  assign chain[CACHE_ENTRIES] = '0;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    fkhc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .up_ent    (up_ent[g]),
      .up_valid  (up_valid[g]),
      .low_valid (low_valid[g]),
      .match_in  (chain[g+1]),
      .match_out (chain[g]),
      .ent       (ent[g]),
      .valid     (valid[g])
    );
  end

  assign cell0_counted = ent[0].key != '0 && ent[0].handle != '0;

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (ctl.flush) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end else if (ctl.add) begin
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
      // An evicted entry's size is subtracted only if its key and handle are nonzero.
      sum_nxt = sum_r + SUM_W'(new_ent.size)
              - ((full && cell0_counted) ? SUM_W'(ent[0].size) : '0);
    end
  end

  always_comb begin
    found      = '0;
    evicted    = '0;
    status_nxt = ST_OK;
    case (cmd)
      CMD_ADD: begin
        if (!add_ok) begin
          status_nxt = ST_REJECT;
        end else if (full) begin
          evicted = ent[0].handle;
        end
      end
      CMD_FIND: begin
        if (chain[0].hit && chain[0].handle != '0) begin
          found = chain[0].handle;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: status_nxt = ST_OK;
    endcase
    stored = (sum_nxt > SUM_W'(STORED_MAX)) ? STORED_MAX : STORED_W'(sum_nxt);
    out_data_nxt = OUT_TDATA_W'({stored, COUNT_W'(fill_nxt), evicted, found});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = status_r;

endmodule

// ===== src/fkhc_cell.sv =====
// ----------------------------------------------------------------------------
// fkhc_cell
// One entry of the cache: holds key, handle and size, loads a new entry or
// its upper neighbor, and takes part in the newest-first match chain.
// ----------------------------------------------------------------------------
module fkhc_cell import fkhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    new_ent,
  input  entry_t    up_ent,
  input  logic      up_valid,
  input  logic      low_valid,
  input  match_t    match_in,
  output match_t    match_out,
  output entry_t    ent,
  output logic      valid
);

  entry_t ent_r, ent_nxt;
  logic   valid_r, valid_nxt;
  logic   match, first;

  assign match = ctl.lookup && valid_r && (ent_r.key == ctl.key);
  assign first = match && !match_in.hit;

  always_comb begin
    match_out.hit    = match_in.hit || match;
    match_out.handle = match_in.hit ? match_in.handle : ent_r.handle;
  end

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    if (ctl.flush) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      ent_nxt   = up_ent;
      valid_nxt = up_valid;
    end else if (ctl.add) begin
      // The first free cell above an occupied one, or cell 0 of an empty table, takes the new entry.
      if (!valid_r && low_valid) begin
        ent_nxt   = new_ent;
        valid_nxt = 1'b1;
      end
    end else if (ctl.commit && first && ent_r.handle == '0) begin
      // A matching entry with a null handle has its key cleared.
      ent_nxt.key = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ent_r <= ent_nxt;
  end

  assign ent   = ent_r;
  assign valid = valid_r;

endmodule

// ===== tb/sv/fifo_keyed_handle_cache_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_keyed_handle_cache_tb
// Drives add, find, flush and unused commands into the keyed handle cache and
// compares each result, field by field, against a cycle-free software copy of
// the cache table kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module fifo_keyed_handle_cache_tb;
  import fkhc_pkg::*;

  typedef struct {
    status_t               status;
    logic [HANDLE_W-1:0]   found;
    logic [HANDLE_W-1:0]   evicted;
    logic [COUNT_W-1:0]    count;
    logic [STORED_W-1:0]   stored;
  } cache_result_t;

  class handle_cache_scoreboard;
    logic [KEY_W-1:0]    keys[CACHE_ENTRIES];
    logic [HANDLE_W-1:0] handles[CACHE_ENTRIES];
    logic [SIZE_W-1:0]   sizes[CACHE_ENTRIES];
    int unsigned         fill;
    cache_result_t       expected_q[$];
    int unsigned         errors;

    function new();
      errors = 0;
      empty_cache();
    endfunction

    function void empty_cache();
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        keys[i] = '0;
        handles[i] = '0;
        sizes[i] = '0;
      end
      fill = 0;
    endfunction

    function logic [STORED_W-1:0] stored_total();
      longint unsigned sum;
      sum = 0;
      for (int i = 0; i < fill && i < CACHE_ENTRIES; i++) begin
        if (keys[i] != 0 && handles[i] != 0) sum += sizes[i];
      end
      if (sum > STORED_MAX) sum = STORED_MAX;
      return sum[STORED_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Applies one accepted transaction to the table and queues its result.
    function void note_input(cmd_t op, logic [KEY_W-1:0] key,
                             logic [HANDLE_W-1:0] hdl, logic [SIZE_W-1:0] sz);
      cache_result_t r;
      int            i;
      bit            matched;
      r.status = ST_OK;
      r.found = '0;
      r.evicted = '0;
      matched = 0;
      case (op)
        CMD_ADD: begin
          if (key == 0 || hdl == 0) begin
            r.status = ST_REJECT;
          end else begin
            if (fill >= CACHE_ENTRIES) begin
              r.evicted = handles[0];
              for (i = 1; i < CACHE_ENTRIES; i++) begin
                keys[i-1] = keys[i];
                handles[i-1] = handles[i];
                sizes[i-1] = sizes[i];
              end
              fill = CACHE_ENTRIES;
            end else begin
              fill++;
            end
            keys[fill-1] = key;
            handles[fill-1] = hdl;
            sizes[fill-1] = sz;
          end
        end
        CMD_FIND: begin
          r.status = ST_MISS;
          if (key != 0) begin
            for (i = int'(fill) - 1; i >= 0; i--) begin
              if (!matched && keys[i] == key) begin
                matched = 1;
                if (handles[i] != 0) begin
                  r.status = ST_OK;
                  r.found = handles[i];
                end else begin
                  keys[i] = '0;
                end
              end
            end
          end
        end
        CMD_FLUSH: empty_cache();
        default: ;
      endcase
      r.count = fill[COUNT_W-1:0];
      r.stored = stored_total();
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser);
      cache_result_t exp;
      logic [HANDLE_W-1:0] got_found;
      logic [HANDLE_W-1:0] got_evicted;
      logic [COUNT_W-1:0]  got_count;
      logic [STORED_W-1:0] got_stored;
      got_found = tdata[31:0];
      got_evicted = tdata[63:32];
      got_count = tdata[68:64];
      got_stored = tdata[96:69];
      if (expected_q.size() == 0) begin
        report("result transaction with no expectation waiting");
      end else begin
        exp = expected_q.pop_front();
        if (tuser !== exp.status)
          report($sformatf("status got %0d exp %0d", tuser, exp.status));
        if (got_found !== exp.found)
          report($sformatf("found_handle got %h exp %h", got_found, exp.found));
        if (got_evicted !== exp.evicted)
          report($sformatf("evicted_handle got %h exp %h", got_evicted, exp.evicted));
        if (got_count !== exp.count)
          report($sformatf("entry_count got %0d exp %0d", got_count, exp.count));
        if (got_stored !== exp.stored)
          report($sformatf("stored_size got %h exp %h", got_stored, exp.stored));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // key[31:0], handle[63:32], frame_size[87:64]
  logic [1:0]             in_tuser;   // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // found_handle[31:0], evicted_handle[63:32],
                                      // entry_count[68:64], stored_size[96:69]
  logic [1:0]             out_tuser;  // status[1:0]

  handle_cache_scoreboard sb = new();

  bit idle_on;
  bit long_hold_req;
  logic [KEY_W-1:0] key_pool[20];

  fifo_keyed_handle_cache uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("fifo_keyed_handle_cache_tb: FAIL");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold that lets the single
  // output register fill and back-pressure the input.
  initial begin : result_sink
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        stall = 80;
      end else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Called at a clock step; returns at the step where the transaction is taken.
  task send_op(cmd_t op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hdl,
               logic [SIZE_W-1:0] sz);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {sz, hdl, key};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, key, hdl, sz);
  endtask

  task wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, 19)];
    if (r < 95) return $urandom;
    return '0;
  endfunction

  initial begin : stimulus
    int r;
    cmd_t op;
    logic [HANDLE_W-1:0] hdl;
    logic [SIZE_W-1:0] sz;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    idle_on = 1;
    long_hold_req = 0;
    for (int i = 0; i < 20; i++) key_pool[i] = $urandom | 32'h1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: misses on an empty table, rejected adds, duplicate keys,
    // the unused command, and a fill past capacity so the oldest is evicted.
    send_op(CMD_FIND, 32'h1, '0, '0);
    send_op(CMD_FIND, '0, '0, '0);
    send_op(CMD_ADD, '0, 32'h5, 24'h10);
    send_op(CMD_ADD, 32'h7, '0, 24'h10);
    send_op(CMD_ADD, '0, '0, 24'hFFFFFF);
    send_op(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_op(CMD_ADD, 32'h1, 32'h1, 24'h0);
    send_op(CMD_ADD, 32'h1, 32'h2, 24'h1);
    send_op(CMD_FIND, 32'h1, '0, '0);
    send_op(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
    for (int i = 0; i < 14; i++)
      send_op(CMD_ADD, 32'h100 + i, 32'h8000_0000 + i, 24'hFFFFFF);
    send_op(CMD_FIND, 32'hFFFF_FFFF, '0, '0);
    send_op(CMD_FLUSH, '0, '0, '0);

    for (int n = 0; n < 900; n++) begin
      if (n == 200) idle_on = 0;
      if (n == 260) idle_on = 1;
      if (n == 300) long_hold_req = 1;
      if (n == 500) wait_all_results();
      if (n == 750) idle_on = 0;
      r = $urandom_range(0, 99);
      if (r < 50) op = CMD_ADD;
      else if (r < 95) op = CMD_FIND;
      else if (r < 97) op = CMD_FLUSH;
      else op = CMD_NOP;
      hdl = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
      sz = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF
                                       : SIZE_W'($urandom_range(0, 24'hFFFFFF));
      send_op(op, pick_key(), hdl, sz);
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fifo_keyed_handle_cache_tb: PASS");
    end else begin
      $display("fifo_keyed_handle_cache_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fkhc_pkg.sv
src/fkhc_cell.sv
src/fifo_keyed_handle_cache.sv
tb/sv/fifo_keyed_handle_cache_tb.sv
